FILE: design/lre_pkg.sv
// Shared types, constants and helper functions for the LED RGB effect envelope.
// Used by every module of the block. Depends on nothing.
`default_nettype none

package lre_pkg;

  localparam int ElapsedW  = 32;                  // width of the elapsed-time field
  localparam int DigitW    = 4;                   // bits folded in per reduction stage
  localparam int NumDigits = ElapsedW / DigitW;   // reduction pipeline depth
  localparam int PhaseW    = 12;                  // holds any phase below the longest period
  localparam int ColorW    = 8;                   // drive level width
  localparam int LvlW      = 10;                  // envelope numerator and divisor width
  localparam int ProdW     = ColorW + LvlW;       // base times numerator
  localparam int QuotW     = ColorW;              // quotient bits, one per divider stage

  typedef enum logic [3:0] {
    FX_SLOW     = 4'd0,
    FX_HARMONY  = 4'd1,
    FX_JUMP     = 4'd2,
    FX_QUICK    = 4'd3,
    FX_MUSIC    = 4'd4,
    FX_SPACE    = 4'd5,
    FX_PAD      = 4'd6,
    FX_LOADING  = 4'd7,
    FX_KILL     = 4'd8,
    FX_SPKILL   = 4'd9,
    FX_VICTORY  = 4'd10
  } lre_effect_t;

  typedef struct packed {
    logic [3:0]        effect;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } lre_side_t;

  typedef struct packed {
    logic [LvlW-1:0] num;
    logic [LvlW-1:0] dvs;
  } lre_seg_t;

  // Period of each effect in milliseconds. Effects without a period use one.
  function automatic logic [PhaseW-1:0] period_of(input logic [3:0] fx);
    logic [PhaseW-1:0] p;
    case (lre_effect_t'(fx))
      FX_SLOW, FX_LOADING, FX_KILL: p = 12'd2000;
      FX_HARMONY:                   p = 12'd1000;
      FX_JUMP:                      p = 12'd420;
      FX_QUICK:                     p = 12'd400;
      FX_SPACE:                     p = 12'd2560;
      FX_PAD:                       p = 12'd240;
      FX_SPKILL:                    p = 12'd1700;
      FX_VICTORY:                   p = 12'd960;
      default:                      p = 12'd1;
    endcase
    return p;
  endfunction

  // One digit of a remainder: (r * 2^DigitW + d) mod m, given r < m.
  function automatic logic [PhaseW-1:0] mod_step(input logic [PhaseW-1:0] r,
                                                 input logic [DigitW-1:0] d,
                                                 input logic [PhaseW-1:0] m);
    logic [PhaseW+DigitW-1:0] x;
    logic [PhaseW+DigitW-1:0] ms;
    x  = {r, d};
    ms = '0;
    for (int j = DigitW - 1; j >= 0; j--) begin
      ms = {{DigitW{1'b0}}, m} << j;
      if (x >= ms) begin
        x = x - ms;
      end
    end
    return x[PhaseW-1:0];
  endfunction

  // Triangle over steps of width w: even steps rise, odd steps fall.
  // The step index never exceeds eight for the phases that reach here.
  function automatic logic [ColorW-1:0] tri_level(input logic [PhaseW-1:0] x,
                                                  input logic [ColorW-1:0] w);
    logic [3:0]        k;
    logic [PhaseW-1:0] off;
    k = '0;
    for (int i = 1; i <= 8; i++) begin
      if (x >= PhaseW'(i) * {4'b0000, w}) begin
        k = k + 4'd1;
      end
    end
    off = x - PhaseW'(k) * {4'b0000, w};
    return k[0] ? (w - off[ColorW-1:0]) : off[ColorW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/lre_mod_reduce.sv
// Pipelined reduction of the elapsed time modulo the period of the selected effect.
// Uses lre_pkg for widths, the period table and the digit step.
`default_nettype none

module lre_mod_reduce (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [lre_pkg::ElapsedW-1:0]  elapsed_ms,
  input  lre_pkg::lre_side_t            side,
  output logic                          out_valid,
  output logic [lre_pkg::PhaseW-1:0]    phase,
  output lre_pkg::lre_side_t            out_side
);

  localparam int N = lre_pkg::NumDigits;

  logic [N-1:0]                     vld_r;
  logic [lre_pkg::PhaseW-1:0]       rem_r  [N];
  logic [lre_pkg::PhaseW-1:0]       per_r  [N];
  logic [lre_pkg::ElapsedW-1:0]     els_r  [N];
  lre_pkg::lre_side_t               side_r [N];
  logic [lre_pkg::PhaseW-1:0]       per_in;

  assign per_in = lre_pkg::period_of(side.effect);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-2:0], in_valid};
    end
  end

  // Each stage folds in the next digit, most significant first.
  always_ff @(posedge clk) begin
    rem_r[0]  <= lre_pkg::mod_step('0,
                   elapsed_ms[lre_pkg::ElapsedW-1 -: lre_pkg::DigitW], per_in);
    per_r[0]  <= per_in;
    els_r[0]  <= elapsed_ms;
    side_r[0] <= side;
    for (int k = 1; k < N; k++) begin
      rem_r[k]  <= lre_pkg::mod_step(rem_r[k-1],
                     els_r[k-1][lre_pkg::ElapsedW-1-lre_pkg::DigitW*k -: lre_pkg::DigitW],
                     per_r[k-1]);
      per_r[k]  <= per_r[k-1];
      els_r[k]  <= els_r[k-1];
      side_r[k] <= side_r[k-1];
    end
  end

  assign out_valid = vld_r[N-1];
  assign phase     = rem_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

`default_nettype wire

FILE: design/lre_segment.sv
// Envelope segment selection: turns effect and phase into a numerator and divisor.
// Uses lre_pkg for the effect codes, the segment type and the triangle helper.
`default_nettype none

module lre_segment (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [lre_pkg::PhaseW-1:0]  phase,
  input  lre_pkg::lre_side_t          side,
  output logic                        out_valid,
  output lre_pkg::lre_seg_t           seg,
  output lre_pkg::lre_side_t          out_side
);

  logic                        valid_r;
  lre_pkg::lre_seg_t           seg_r;
  lre_pkg::lre_seg_t           seg_nxt;
  lre_pkg::lre_side_t          side_r;
  logic [lre_pkg::PhaseW-1:0]  t;
  logic [lre_pkg::PhaseW-1:0]  n12;
  logic [lre_pkg::LvlW-1:0]    d10;

  assign t = phase;

  always_comb begin
    n12 = '0;
    d10 = 10'd1;
    case (lre_pkg::lre_effect_t'(side.effect))
      lre_pkg::FX_SLOW: begin
        d10 = 10'd1000;
        n12 = (t < 12'd1000) ? t : 12'd2000 - t;
      end
      lre_pkg::FX_HARMONY: begin
        d10 = 10'd330;
        if (t < 12'd330)       n12 = t;
        else if (t <= 12'd660) n12 = 12'd660 - t;
        else                   n12 = '0;
      end
      lre_pkg::FX_JUMP: begin
        d10 = 10'd160;
        if (t < 12'd160)       n12 = t;
        else if (t <= 12'd320) n12 = 12'd320 - t;
        else                   n12 = '0;
      end
      lre_pkg::FX_QUICK: begin
        d10 = 10'd200;
        n12 = (t < 12'd200) ? t : 12'd400 - t;
      end
      lre_pkg::FX_MUSIC: begin
        n12 = 12'd1;
        d10 = 10'd1;
      end
      lre_pkg::FX_SPACE: begin
        if (t < 12'd120) begin
          n12 = t;             d10 = 10'd120;
        end else if (t < 12'd420) begin
          n12 = 12'd1;         d10 = 10'd1;
        end else if (t < 12'd600) begin
          n12 = 12'd600 - t;   d10 = 10'd180;
        end else if (t < 12'd1860) begin
          n12 = {4'b0000, lre_pkg::tri_level(t - 12'd600, 8'd140)};
          d10 = 10'd140;
        end else if (t < 12'd2160) begin
          n12 = 12'd1;         d10 = 10'd1;
        end else begin
          n12 = 12'd2560 - t;  d10 = 10'd400;
        end
      end
      lre_pkg::FX_PAD: begin
        if (t < 12'd80) begin
          n12 = t;             d10 = 10'd80;
        end else if (t < 12'd160) begin
          n12 = 12'd1;         d10 = 10'd1;
        end else begin
          n12 = 12'd240 - t;   d10 = 10'd80;
        end
      end
      lre_pkg::FX_LOADING: begin
        d10 = 10'd1000;
        n12 = (t < 12'd1000) ? 12'd1000 - t : t - 12'd1000;
      end
      lre_pkg::FX_KILL: begin
        if (t < 12'd250) begin
          n12 = t;             d10 = 10'd250;
        end else if (t < 12'd1500) begin
          n12 = 12'd1;         d10 = 10'd1;
        end else begin
          n12 = 12'd2000 - t;  d10 = 10'd500;
        end
      end
      lre_pkg::FX_SPKILL: begin
        d10 = 10'd125;
        if (t < 12'd125)       n12 = 12'd125 - t;
        else if (t < 12'd250)  n12 = t - 12'd125;
        else if (t < 12'd375) begin
          n12 = 12'd1;         d10 = 10'd1;
        end
        else if (t < 12'd500)  n12 = 12'd500 - t;
        else if (t < 12'd625)  n12 = t - 12'd500;
        else if (t < 12'd750) begin
          n12 = 12'd1;         d10 = 10'd1;
        end
        else if (t < 12'd875)  n12 = 12'd875 - t;
        else if (t < 12'd1000) n12 = t - 12'd875;
        else begin
          n12 = 12'd1700 - t;  d10 = 10'd700;
        end
      end
      lre_pkg::FX_VICTORY: begin
        n12 = {4'b0000, lre_pkg::tri_level(t, 8'd160)};
        d10 = 10'd160;
      end
      default: begin
        n12 = '0;
        d10 = 10'd1;
      end
    endcase
    seg_nxt.num = n12[lre_pkg::LvlW-1:0];
    seg_nxt.dvs = d10;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    seg_r  <= seg_nxt;
    side_r <= side;
  end

  assign out_valid = valid_r;
  assign seg       = seg_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

FILE: design/lre_lane.sv
// One color lane: multiplies the base level by the numerator, then divides by the
// divisor in a restoring pipeline, one quotient bit per stage. Uses lre_pkg widths.
`default_nettype none

module lre_lane (
  input  logic                        clk,
  input  logic [lre_pkg::ColorW-1:0]  base,
  input  logic [lre_pkg::LvlW-1:0]    num,
  input  logic [lre_pkg::LvlW-1:0]    dvs,
  output logic [lre_pkg::ColorW-1:0]  level
);

  localparam int Q  = lre_pkg::QuotW;
  localparam int PW = lre_pkg::ProdW;
  localparam int LW = lre_pkg::LvlW;

  logic [PW-1:0] prod_r;
  logic [LW-1:0] dvs0_r;
  logic [PW-1:0] rem_r   [Q];
  logic [LW-1:0] dvs_r   [Q];
  logic [Q-1:0]  quo_r   [Q];
  logic [PW-1:0] rem_nxt [Q];
  logic [Q-1:0]  quo_nxt [Q];
  logic [PW-1:0] rem_in  [Q];
  logic [LW-1:0] dvs_in  [Q];
  logic [Q-1:0]  quo_in  [Q];

  always_ff @(posedge clk) begin
    prod_r <= {{(PW-lre_pkg::ColorW){1'b0}}, base} * {{(PW-LW){1'b0}}, num};
    dvs0_r <= dvs;
  end

  always_comb begin
    logic [PW-1:0] ds;
    ds = '0;
    for (int s = 0; s < Q; s++) begin
      if (s == 0) begin
        rem_in[s] = prod_r;
        dvs_in[s] = dvs0_r;
        quo_in[s] = '0;
      end else begin
        rem_in[s] = rem_r[s-1];
        dvs_in[s] = dvs_r[s-1];
        quo_in[s] = quo_r[s-1];
      end
      ds = {{(PW-LW){1'b0}}, dvs_in[s]} << (Q - 1 - s);
      if (rem_in[s] >= ds) begin
        rem_nxt[s] = rem_in[s] - ds;
        quo_nxt[s] = {quo_in[s][Q-2:0], 1'b1};
      end else begin
        rem_nxt[s] = rem_in[s];
        quo_nxt[s] = {quo_in[s][Q-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < Q; s++) begin
      rem_r[s] <= rem_nxt[s];
      dvs_r[s] <= dvs_in[s];
      quo_r[s] <= quo_nxt[s];
    end
  end

  assign level = quo_r[Q-1];

endmodule

`default_nettype wire

FILE: design/led_rgb_effect_envelope.sv
// Top level of the LED RGB effect envelope: phase reduction, segment selection,
// three color lanes and the merging output register. Uses lre_pkg and all lre_ modules.
//
//   Channel   Handshake        Payload
//   input     start / busy     in_effect, in_elapsed_ms, in_red, in_green, in_blue
//   result    out_valid        out_red_level, out_green_level, out_blue_level
//
// An item is transferred at every rising edge where start is high; busy is always low,
// so one item can be taken in every cycle. Each result passes in order through the
// modulo reduction stages (one 4-bit elapsed-time digit per stage), the segment selection
// register, the multiply register and the restoring divider stages of the color lanes,
// and the output register. The receiver cannot stall; out_valid is high for exactly one
// cycle per result. Reset is synchronous, active low, and clears only valids.
`default_nettype none

module led_rgb_effect_envelope (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [3:0]                    in_effect,
  input  logic [lre_pkg::ElapsedW-1:0]  in_elapsed_ms,
  input  logic [lre_pkg::ColorW-1:0]    in_red,
  input  logic [lre_pkg::ColorW-1:0]    in_green,
  input  logic [lre_pkg::ColorW-1:0]    in_blue,
  output logic                          out_valid,
  output logic [lre_pkg::ColorW-1:0]    out_red_level,
  output logic [lre_pkg::ColorW-1:0]    out_green_level,
  output logic [lre_pkg::ColorW-1:0]    out_blue_level
);

  // The lanes hold one multiply register plus one divider register per quotient bit.
  localparam int LaneLat = 1 + lre_pkg::QuotW;

  lre_pkg::lre_side_t          in_side;
  logic                        mod_valid;
  logic [lre_pkg::PhaseW-1:0]  mod_phase;
  lre_pkg::lre_side_t          mod_side;
  logic                        seg_valid;
  lre_pkg::lre_seg_t           seg;
  lre_pkg::lre_side_t          seg_side;
  logic [LaneLat-1:0]          lane_vld_r;
  logic [lre_pkg::ColorW-1:0]  red_lvl;
  logic [lre_pkg::ColorW-1:0]  green_lvl;
  logic [lre_pkg::ColorW-1:0]  blue_lvl;
  logic                        out_valid_r;
  logic [lre_pkg::ColorW-1:0]  red_r;
  logic [lre_pkg::ColorW-1:0]  green_r;
  logic [lre_pkg::ColorW-1:0]  blue_r;

  // Every stage advances each cycle, so the block never refuses a transfer.
  assign busy = 1'b0;

  assign in_side.effect = in_effect;
  assign in_side.red    = in_red;
  assign in_side.green  = in_green;
  assign in_side.blue   = in_blue;

  // Elapsed time modulo the period of the selected effect.
  lre_mod_reduce u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start),
    .elapsed_ms (in_elapsed_ms),
    .side       (in_side),
    .out_valid  (mod_valid),
    .phase      (mod_phase),
    .out_side   (mod_side)
  );

  // Piecewise-linear envelope: numerator and divisor for this phase.
  lre_segment u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mod_valid),
    .phase     (mod_phase),
    .side      (mod_side),
    .out_valid (seg_valid),
    .seg       (seg),
    .out_side  (seg_side)
  );

  // Three identical lanes scale the colors side by side with the same fraction.
  lre_lane u_lane_red (
    .clk   (clk),
    .base  (seg_side.red),
    .num   (seg.num),
    .dvs   (seg.dvs),
    .level (red_lvl)
  );

  lre_lane u_lane_green (
    .clk   (clk),
    .base  (seg_side.green),
    .num   (seg.num),
    .dvs   (seg.dvs),
    .level (green_lvl)
  );

  lre_lane u_lane_blue (
    .clk   (clk),
    .base  (seg_side.blue),
    .num   (seg.num),
    .dvs   (seg.dvs),
    .level (blue_lvl)
  );

  // The valid marker travels alongside the lanes, which carry payload only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lane_vld_r  <= {lane_vld_r[LaneLat-2:0], seg_valid};
      out_valid_r <= lane_vld_r[LaneLat-1];
    end
  end

  // Merge stage: the three lane results are registered together as one result.
  always_ff @(posedge clk) begin
    red_r   <= red_lvl;
    green_r <= green_lvl;
    blue_r  <= blue_lvl;
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;

endmodule

`default_nettype wire

FILE: tb/sv/led_rgb_effect_envelope_tb.sv
// Self-checking testbench for the LED RGB effect envelope: a directed table, then bursts
// of random items, each result checked against the table's expected value or a predictor written in this file.
// Depends on lre_pkg and the led_rgb_effect_envelope top level.
`timescale 1ns / 1ps

module led_rgb_effect_envelope_tb;
  import lre_pkg::*;

  // Expected latency of the block, and the extra wait of the drain at the end.
  localparam int Latency      = 19;
  localparam int DrainCycles  = 2 * Latency;
  localparam int WatchdogMax  = 1000;
  localparam int RandomItems  = 1950;
  localparam int ReportMax    = 10;
  localparam int NumDirected  = 25;

  // Effect codes above the last named envelope all produce black.
  localparam logic [3:0] FxFirstUnknown = 4'd11;
  localparam logic [3:0] FxLastUnknown  = 4'd15;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } level_t;

  // One row of the directed table. When typed is set, want holds a result that can be
  // read straight off the envelope definition; otherwise the predictor supplies it.
  typedef struct packed {
    logic [3:0]          effect;
    logic [ElapsedW-1:0] elapsed;
    level_t              base;
    logic                typed;
    level_t              want;
  } stim_row_t;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                start           = 1'b0;
  logic                busy;
  logic [3:0]          in_effect       = '0;
  logic [ElapsedW-1:0] in_elapsed_ms   = '0;
  logic [ColorW-1:0]   in_red          = '0;
  logic [ColorW-1:0]   in_green        = '0;
  logic [ColorW-1:0]   in_blue         = '0;
  logic                out_valid;
  logic [ColorW-1:0]   out_red_level;
  logic [ColorW-1:0]   out_green_level;
  logic [ColorW-1:0]   out_blue_level;

  // Sideband that travels with the item being offered, so that the monitor knows
  // whether a typed expectation belongs to the transfer it sees.
  logic   row_typed = 1'b0;
  level_t row_want  = '0;

  level_t pending_levels[$];
  int     mismatch_count = 0;
  int     idle_cycles    = 0;

  stim_row_t dir_rows [NumDirected] = '{
    // Music passes the base levels through, at both ends of the time range.
    '{FX_MUSIC,   32'd0,          '{8'd255, 8'd128, 8'd1},   1'b1, '{8'd255, 8'd128, 8'd1}},
    '{FX_MUSIC,   32'hFFFF_FFFF,  '{8'd0,   8'd255, 8'd170}, 1'b1, '{8'd0,   8'd255, 8'd170}},
    // Unknown effects give black.
    '{FxFirstUnknown, 32'd1234,   '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{FxLastUnknown,  32'hFFFF_FFFF, '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    // Slow breathing: dark at the start, full at the peak, then the top of the time range.
    '{FX_SLOW,    32'd0,          '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{FX_SLOW,    32'd1000,       '{8'd255, 8'd200, 8'd1},   1'b1, '{8'd255, 8'd200, 8'd1}},
    '{FX_SLOW,    32'hFFFF_FFFF,  '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    // Special kill starts at full and falls over its first segment.
    '{FX_SPKILL,  32'd0,          '{8'd255, 8'd100, 8'd7},   1'b1, '{8'd255, 8'd100, 8'd7}},
    '{FX_SPKILL,  32'd124,        '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{FX_SPKILL,  32'd250,        '{8'd9,   8'd90,  8'd255}, 1'b1, '{8'd9,   8'd90,  8'd255}},
    // Loading falls to dark at mid-period and rises again from there.
    '{FX_LOADING, 32'd0,          '{8'd255, 8'd17,  8'd128}, 1'b1, '{8'd255, 8'd17,  8'd128}},
    '{FX_LOADING, 32'd1000,       '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{FX_LOADING, 32'd1999,       '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    // Peaks and dead tails of harmony and jump, and the peak of quick.
    '{FX_HARMONY, 32'd330,        '{8'd255, 8'd1,   8'd64},  1'b1, '{8'd255, 8'd1,   8'd64}},
    '{FX_HARMONY, 32'd661,        '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{FX_JUMP,    32'd160,        '{8'd200, 8'd100, 8'd50},  1'b1, '{8'd200, 8'd100, 8'd50}},
    '{FX_JUMP,    32'd321,        '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{FX_QUICK,   32'd200,        '{8'd33,  8'd255, 8'd0},   1'b1, '{8'd33,  8'd255, 8'd0}},
    // Space: plateau, first triangle peak, and the last millisecond of the fade; then pad, kill and victory.
    '{FX_SPACE,   32'd300,        '{8'd255, 8'd128, 8'd64},  1'b1, '{8'd255, 8'd128, 8'd64}},
    '{FX_SPACE,   32'd740,        '{8'd1,   8'd254, 8'd127}, 1'b1, '{8'd1,   8'd254, 8'd127}},
    '{FX_SPACE,   32'd2559,       '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{FX_PAD,     32'd100,        '{8'd77,  8'd88,  8'd99},  1'b1, '{8'd77,  8'd88,  8'd99}},
    '{FX_KILL,    32'd1000,       '{8'd255, 8'd0,   8'd255}, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{FX_VICTORY, 32'd160,        '{8'd12,  8'd34,  8'd56},  1'b1, '{8'd12,  8'd34,  8'd56}},
    '{FX_VICTORY, 32'd959,        '{8'd255, 8'd255, 8'd255}, 1'b0, '0}
  };

  led_rgb_effect_envelope i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_effect       (in_effect),
    .in_elapsed_ms   (in_elapsed_ms),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level)
  );

  always #5 clk = ~clk;

  // Length of one cycle of each envelope; effects without a period repeat every 1 ms.
  function automatic logic [31:0] effect_period(input logic [3:0] fx);
    case (lre_effect_t'(fx))
      FX_SLOW, FX_LOADING, FX_KILL: return 32'd2000;
      FX_HARMONY:                   return 32'd1000;
      FX_JUMP:                      return 32'd420;
      FX_QUICK:                     return 32'd400;
      FX_SPACE:                     return 32'd2560;
      FX_PAD:                       return 32'd240;
      FX_SPKILL:                    return 32'd1700;
      FX_VICTORY:                   return 32'd960;
      default:                      return 32'd1;
    endcase
  endfunction

  // Triangle of steps w wide: even steps rise from zero, odd steps fall from full.
  // Returns the numerator in the upper half and the divisor in the lower half.
  function automatic logic [63:0] triangle_seg(input logic [31:0] x, input logic [31:0] w);
    logic [31:0] k;
    logic [31:0] off;
    k   = x / w;
    off = x % w;
    return {(k[0] ? (w - off) : off), w};
  endfunction

  // Envelope fraction for the given effect and time, applied to all three base levels.
  function automatic level_t predict_levels(input logic [3:0] fx, input logic [31:0] e,
                                            input level_t base);
    logic [31:0] t;
    logic [31:0] num;
    logic [31:0] dvs;
    level_t      lv;
    t = e % effect_period(fx);
    case (lre_effect_t'(fx))
      FX_SLOW:
        if (t < 1000) {num, dvs} = {t, 32'd1000};
        else          {num, dvs} = {32'd2000 - t, 32'd1000};
      FX_HARMONY:
        if (t < 330)       {num, dvs} = {t, 32'd330};
        else if (t <= 660) {num, dvs} = {32'd660 - t, 32'd330};
        else               {num, dvs} = {32'd0, 32'd330};
      FX_JUMP:
        if (t < 160)       {num, dvs} = {t, 32'd160};
        else if (t <= 320) {num, dvs} = {32'd320 - t, 32'd160};
        else               {num, dvs} = {32'd0, 32'd160};
      FX_QUICK:
        if (t < 200) {num, dvs} = {t, 32'd200};
        else         {num, dvs} = {32'd400 - t, 32'd200};
      FX_MUSIC:
        {num, dvs} = {32'd1, 32'd1};
      FX_SPACE:
        if (t < 120)       {num, dvs} = {t, 32'd120};
        else if (t < 420)  {num, dvs} = {32'd1, 32'd1};
        else if (t < 600)  {num, dvs} = {32'd600 - t, 32'd180};
        else if (t < 1860) {num, dvs} = triangle_seg(t - 32'd600, 32'd140);
        else if (t < 2160) {num, dvs} = {32'd1, 32'd1};
        else               {num, dvs} = {32'd2560 - t, 32'd400};
      FX_PAD:
        if (t < 80)       {num, dvs} = {t, 32'd80};
        else if (t < 160) {num, dvs} = {32'd1, 32'd1};
        else              {num, dvs} = {32'd240 - t, 32'd80};
      FX_LOADING:
        if (t < 1000) {num, dvs} = {32'd1000 - t, 32'd1000};
        else          {num, dvs} = {t - 32'd1000, 32'd1000};
      FX_KILL:
        if (t < 250)       {num, dvs} = {t, 32'd250};
        else if (t < 1500) {num, dvs} = {32'd1, 32'd1};
        else               {num, dvs} = {32'd2000 - t, 32'd500};
      FX_SPKILL:
        if (t < 125)       {num, dvs} = {32'd125 - t, 32'd125};
        else if (t < 250)  {num, dvs} = {t - 32'd125, 32'd125};
        else if (t < 375)  {num, dvs} = {32'd1, 32'd1};
        else if (t < 500)  {num, dvs} = {32'd500 - t, 32'd125};
        else if (t < 625)  {num, dvs} = {t - 32'd500, 32'd125};
        else if (t < 750)  {num, dvs} = {32'd1, 32'd1};
        else if (t < 875)  {num, dvs} = {32'd875 - t, 32'd125};
        else if (t < 1000) {num, dvs} = {t - 32'd875, 32'd125};
        else               {num, dvs} = {32'd1700 - t, 32'd700};
      FX_VICTORY:
        {num, dvs} = triangle_seg(t, 32'd160);
      default:
        {num, dvs} = {32'd0, 32'd1};
    endcase
    lv.red   = ColorW'((32'(base.red)   * num) / dvs);
    lv.green = ColorW'((32'(base.green) * num) / dvs);
    lv.blue  = ColorW'((32'(base.blue)  * num) / dvs);
    return lv;
  endfunction

  // Picks a phase within one millisecond of a segment edge of the given effect.
  function automatic logic [31:0] edge_phase(input logic [3:0] fx);
    logic [31:0] b;
    int          idx;
    case (lre_effect_t'(fx))
      FX_SLOW, FX_LOADING: b = 32'd1000 * $urandom_range(0, 1);
      FX_HARMONY:          b = 32'd330 * $urandom_range(0, 2);
      FX_JUMP:             b = 32'd160 * $urandom_range(0, 2);
      FX_QUICK:            b = 32'd200 * $urandom_range(0, 1);
      FX_PAD:              b = 32'd80 * $urandom_range(0, 2);
      FX_SPKILL:           b = 32'd125 * $urandom_range(0, 8);
      FX_VICTORY:          b = 32'd160 * $urandom_range(0, 5);
      FX_KILL: begin
        idx = $urandom_range(0, 2);
        b = (idx == 0) ? 32'd0 : (idx == 1) ? 32'd250 : 32'd1500;
      end
      FX_SPACE: begin
        // Plateau and fade edges, plus every step edge of the triangle run.
        idx = $urandom_range(0, 13);
        if (idx == 0)       b = 32'd0;
        else if (idx == 1)  b = 32'd120;
        else if (idx == 2)  b = 32'd420;
        else if (idx == 13) b = 32'd2160;
        else                b = 32'd600 + 32'd140 * (idx - 3);
      end
      default: b = 32'd0;
    endcase
    return (b + effect_period(fx) + $urandom_range(0, 2) - 1) % effect_period(fx);
  endfunction

  function automatic logic [ColorW-1:0] random_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ColorW'($urandom);
    endcase
  endfunction

  // Offers one item and returns once it has been transferred. start is raised here
  // and only lowered by the caller when a gap follows.
  task automatic send_item(input logic [3:0] fx, input logic [31:0] e, input level_t base,
                           input logic typed, input level_t want);
    start         <= 1'b1;
    in_effect     <= fx;
    in_elapsed_ms <= e;
    in_red        <= base.red;
    in_green      <= base.green;
    in_blue       <= base.blue;
    row_typed     <= typed;
    row_want      <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Monitor and scoreboard. Everything is sampled right after the rising edge, so the
  // values seen are those that were stable before it.
  always @(posedge clk) begin
    level_t seen;
    level_t want;
    if (rst_n) begin
      if (start && !busy) begin
        pending_levels.push_back(row_typed ? row_want :
            predict_levels(in_effect, in_elapsed_ms, '{in_red, in_green, in_blue}));
      end
      if (out_valid) begin
        seen = '{out_red_level, out_green_level, out_blue_level};
        if (pending_levels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax) begin
            $display("unexpected result r=%0d g=%0d b=%0d", seen.red, seen.green, seen.blue);
          end
        end else begin
          want = pending_levels.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= ReportMax) begin
              $display("level mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       want.red, want.green, want.blue, seen.red, seen.green, seen.blue);
            end
          end
        end
      end
      // The watchdog restarts on every transfer in either direction.
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogMax) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [3:0]  fx;
    logic [63:0] e64;
    logic [31:0] per;
    level_t      base;
    int          sent;
    int          burst;
    int          gap;
    bit          drain;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, back to back.
    for (int i = 0; i < NumDirected; i++) begin
      send_item(dir_rows[i].effect, dir_rows[i].elapsed, dir_rows[i].base,
                dir_rows[i].typed, dir_rows[i].want);
    end
    start <= 1'b0;
    // Let the pipeline empty completely before the random part begins.
    while (pending_levels.size() != 0) @(posedge clk);

    // Random part: bursts of items with gaps of random length between them. Most items
    // land near a segment edge so that both sides of every comparison are hit.
    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < RandomItems; i++) begin
        fx   = 4'($urandom_range(FX_SLOW, FX_VICTORY));
        base = '{random_color(), random_color(), random_color()};
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            per = effect_period(fx);
            e64 = {32'd0, $urandom};
            e64 = e64 - (e64 % per) + edge_phase(fx);
            if (e64 > 64'hFFFF_FFFF) e64 = e64 - per;
          end
          6: e64 = {32'd0, $urandom};
          7: e64 = 64'($urandom_range(0, 4095));
          8: begin
            fx  = $urandom_range(0, 1) ? 4'(FX_MUSIC) :
                  4'($urandom_range(FxFirstUnknown, FxLastUnknown));
            e64 = {32'd0, $urandom};
          end
          default: begin
            e64 = $urandom_range(0, 1) ? 64'($urandom_range(0, 3)) :
                  64'(32'hFFFF_FFFF - $urandom_range(0, 3));
          end
        endcase
        send_item(fx, e64[31:0], base, 1'b0, '0);
        sent++;
      end
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      drain = ($urandom_range(0, 39) == 0);
      if (gap > 0 || drain) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
        if (drain) begin
          while (pending_levels.size() != 0) @(posedge clk);
        end
      end
    end
    start <= 1'b0;

    // Wait for the last results, then a little longer to catch any stray strobe.
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && pending_levels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: led_rgb_effect_envelope.f
design/lre_pkg.sv
design/lre_mod_reduce.sv
design/lre_segment.sv
design/lre_lane.sv
design/led_rgb_effect_envelope.sv
tb/sv/led_rgb_effect_envelope_tb.sv
